### rtl/core/vst_pkg.sv
// Package: widths, constants, register indexes and helpers of the vertex screen transform.
package vst_pkg;

  localparam int unsigned CoefW      = 16;
  localparam int unsigned PosW       = 32;
  localparam int unsigned ProdW      = CoefW + PosW;
  localparam int unsigned ClipW      = 50;
  localparam int unsigned FracW      = 16;
  localparam int unsigned QuotW      = 40;
  localparam int unsigned IntLimW    = QuotW - FracW;
  localparam int unsigned StepsPerSt = 2;
  localparam int unsigned DivStages  = QuotW / StepsPerSt;
  localparam int unsigned M2W        = QuotW + 3;
  localparam int unsigned SizeW      = 13;
  localparam int unsigned ScaleW     = M2W + SizeW + 1;
  localparam int unsigned YW         = ScaleW + 1;
  localparam int unsigned RowW       = 64;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned Latency    = DivStages + 6;

  localparam logic [RowW-1:0]  Row0Rst = 64'h0000_0000_0000_0100;
  localparam logic [RowW-1:0]  Row1Rst = 64'h0000_0000_0100_0000;
  localparam logic [RowW-1:0]  Row2Rst = 64'h0000_0100_0000_0000;
  localparam logic [RowW-1:0]  Row3Rst = 64'h0100_0000_0000_0000;
  localparam logic [SizeW-1:0] VpWRst  = 13'd640;
  localparam logic [SizeW-1:0] VpHRst  = 13'd480;
  localparam logic [SizeW-1:0] FrHRst  = 13'd480;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRow0 = 3'd0,
    CfgRow1 = 3'd1,
    CfgRow2 = 3'd2,
    CfgRow3 = 3'd3,
    CfgVpW  = 3'd4,
    CfgVpH  = 3'd5,
    CfgFrH  = 3'd6
  } cfg_idx_e;

  typedef logic [RowW-1:0] row_t;
  typedef logic signed [ClipW-1:0] clip_t;

  function automatic logic [PosW-1:0] sat32(input logic signed [YW-1:0] v);
    logic signed [YW-1:0] hi;
    logic signed [YW-1:0] lo;
    hi = YW'(signed'(33'sh0_7FFF_FFFF));
    lo = YW'(signed'(33'sh1_8000_0000));
    if (v > hi) begin
      return 32'h7FFF_FFFF;
    end else if (v < lo) begin
      return 32'h8000_0000;
    end
    return v[PosW-1:0];
  endfunction

endpackage

### rtl/core/vst_if.sv
// Interfaces: vertex input channel and screen result channel.
interface vst_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [31:0]             pos_x;
  logic signed [31:0]             pos_y;
  logic signed [31:0]             pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface vst_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [31:0]             screen_x;
  logic signed [31:0]             screen_y;
  logic signed [31:0]             depth;
  logic                           w_zero;
  modport source (output valid, screen_x, screen_y, depth, w_zero, input ready);
  modport sink   (input valid, screen_x, screen_y, depth, w_zero, output ready);
endinterface

### rtl/core/vst_mac.sv
// Matrix times vertex: product stage then row sum stage.
module vst_mac (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [31:0]      x_i,
  input  logic signed [31:0]      y_i,
  input  logic signed [31:0]      z_i,
  input  vst_pkg::row_t           row_i [4],
  output vst_pkg::clip_t          clip_o [4]
);
  import vst_pkg::*;

  logic signed [ProdW-1:0] prod_q [4][4];
  clip_t                   clip_q [4];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 4; r++) begin
        prod_q[r][0] <= signed'(row_i[r][15:0])  * x_i;
        prod_q[r][1] <= signed'(row_i[r][31:16]) * y_i;
        prod_q[r][2] <= signed'(row_i[r][47:32]) * z_i;
        // w is 1.0: a shift, no multiplier
        prod_q[r][3] <= ProdW'(signed'({row_i[r][63:48], 16'h0000}));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 4; r++) begin
        clip_q[r] <= ClipW'(prod_q[r][0]) + ClipW'(prod_q[r][1])
                   + ClipW'(prod_q[r][2]) + ClipW'(prod_q[r][3]);
      end
    end
  end

  assign clip_o = clip_q;

endmodule

### rtl/core/vst_div.sv
// Pipelined restoring divider lane: two quotient bits per stage.
module vst_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [vst_pkg::ClipW-1:0]  ua_i,
  input  logic [vst_pkg::ClipW-1:0]  uw_i,
  input  logic                       neg_i,
  input  logic                       ovf_i,
  output logic [vst_pkg::QuotW-1:0]  q_o,
  output logic                       neg_o,
  output logic                       ovf_o
);
  import vst_pkg::*;

  // rem: partial remainder, sq: unconsumed dividend bits shifting out, quotient bits in
  logic [ClipW-1:0] rem_q [1:DivStages];
  logic [QuotW-1:0] sq_q  [1:DivStages];
  logic [ClipW-1:0] uw_q  [1:DivStages];
  logic             neg_q [1:DivStages];
  logic             ovf_q [1:DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stg
    logic [ClipW-1:0] rem_in, rem_d;
    logic [QuotW-1:0] sq_in, sq_d;
    logic [ClipW-1:0] uw_in;
    logic             neg_in, ovf_in;

    if (s == 0) begin : g_head
      assign rem_in = ClipW'(ua_i[ClipW-1:IntLimW]);
      assign sq_in  = {ua_i[IntLimW-1:0], {FracW{1'b0}}};
      assign uw_in  = uw_i;
      assign neg_in = neg_i;
      assign ovf_in = ovf_i;
    end else begin : g_body
      assign rem_in = rem_q[s];
      assign sq_in  = sq_q[s];
      assign uw_in  = uw_q[s];
      assign neg_in = neg_q[s];
      assign ovf_in = ovf_q[s];
    end

    always_comb begin
      logic [ClipW:0] trial;
      rem_d = rem_in;
      sq_d  = sq_in;
      for (int k = 0; k < StepsPerSt; k++) begin
        trial = {rem_d, sq_d[QuotW-1]};
        if (trial >= {1'b0, uw_in}) begin
          rem_d = ClipW'(trial - {1'b0, uw_in});
          sq_d  = {sq_d[QuotW-2:0], 1'b1};
        end else begin
          rem_d = trial[ClipW-1:0];
          sq_d  = {sq_d[QuotW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= rem_d;
        sq_q[s+1]  <= sq_d;
        uw_q[s+1]  <= uw_in;
        neg_q[s+1] <= neg_in;
        ovf_q[s+1] <= ovf_in;
      end
    end
  end

  assign q_o   = sq_q[DivStages];
  assign neg_o = neg_q[DivStages];
  assign ovf_o = ovf_q[DivStages];

endmodule

### rtl/core/vst_post.sv
// Sign and bias, viewport scaling, halving, flip and saturation.
module vst_post (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [vst_pkg::QuotW-1:0]  q_i [3],
  input  logic                       neg_i [3],
  input  logic                       ovf_i [3],
  input  logic                       wz_i,
  input  logic [vst_pkg::SizeW-1:0]  vp_w_i,
  input  logic [vst_pkg::SizeW-1:0]  vp_h_i,
  input  logic [vst_pkg::SizeW-1:0]  fr_h_i,
  output logic [31:0]                sx_o,
  output logic [31:0]                sy_o,
  output logic [31:0]                dz_o,
  output logic                       wz_o
);
  import vst_pkg::*;

  logic signed [M2W-1:0]    m2_q [3];
  logic                     wz_a_q, wz_b_q, wz_c_q;
  logic signed [ScaleW-1:0] sc_q [3];
  logic [31:0]              sx_q, sy_q, dz_q;

  // stage A: signed quotient plus one
  always_ff @(posedge clk_i) begin
    logic [QuotW:0]          qm;
    logic signed [M2W-1:0]   sq;
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        qm = ovf_i[i] ? {1'b1, {QuotW{1'b0}}} : {1'b0, q_i[i]};
        sq = neg_i[i] ? -signed'(M2W'(qm)) : signed'(M2W'(qm));
        m2_q[i] <= sq + M2W'(signed'(18'sh1_0000));
      end
      wz_a_q <= wz_i;
    end
  end

  // stage B: viewport scaling
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_q[0] <= m2_q[0] * signed'({1'b0, vp_w_i});
      sc_q[1] <= m2_q[1] * signed'({1'b0, vp_h_i});
      sc_q[2] <= ScaleW'(m2_q[2]);
      wz_b_q  <= wz_a_q;
    end
  end

  // stage C: floor halving, y flip, saturation
  always_ff @(posedge clk_i) begin
    logic signed [YW-1:0] hx, hy, hz, fy;
    if (en_i) begin
      hx = YW'(sc_q[0] >>> 1);
      hy = YW'(sc_q[1] >>> 1);
      hz = YW'(sc_q[2] >>> 1);
      fy = signed'(YW'({fr_h_i, {FracW{1'b0}}})) - hy;
      sx_q   <= wz_b_q ? '0 : sat32(hx);
      sy_q   <= wz_b_q ? '0 : sat32(fy);
      dz_q   <= wz_b_q ? '0 : sat32(hz);
      wz_c_q <= wz_b_q;
    end
  end

  assign sx_o = sx_q;
  assign sy_o = sy_q;
  assign dz_o = dz_q;
  assign wz_o = wz_c_q;

endmodule

### rtl/core/vertex_screen_transform_unit.sv
// Top level: vertex to screen transform with perspective divide and viewport map.
// Pipeline order from input transfer to result valid: MAC, prep, divide, post.
// Throughput: one vertex per cycle; the three 40-bit quotient dividers are fully pipelined.
// The whole pipeline holds while the output register is full and not taken.
// Reset (async, active low) clears all valid bits and loads the identity matrix
// and a 640 x 480 viewport and frame.
module vertex_screen_transform_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  vst_in_if.sink                       vtx_i,
  vst_out_if.source                    scr_o,
  input  logic                         cfg_we_i,
  input  logic [vst_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vst_pkg::RowW-1:0]     cfg_data_i
);
  import vst_pkg::*;

  // configuration registers
  row_t             row_q [4];
  logic [SizeW-1:0] vp_w_q, vp_h_q, fr_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= Row0Rst;
      row_q[1] <= Row1Rst;
      row_q[2] <= Row2Rst;
      row_q[3] <= Row3Rst;
      vp_w_q   <= VpWRst;
      vp_h_q   <= VpHRst;
      fr_h_q   <= FrHRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRow0: row_q[0] <= cfg_data_i;
        CfgRow1: row_q[1] <= cfg_data_i;
        CfgRow2: row_q[2] <= cfg_data_i;
        CfgRow3: row_q[3] <= cfg_data_i;
        CfgVpW:  vp_w_q   <= cfg_data_i[SizeW-1:0];
        CfgVpH:  vp_h_q   <= cfg_data_i[SizeW-1:0];
        CfgFrH:  fr_h_q   <= cfg_data_i[SizeW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // Global advance: every stage moves when the output register is empty or
  // its result is transferred this cycle. Bubbles travel as cleared valid bits.
  logic               en;
  logic [Latency-1:0] vld_q;

  assign en          = !vld_q[Latency-1] || scr_o.ready;
  assign vtx_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Latency-2:0], vtx_i.valid};
    end
  end

  // clip = M * [x y z 1], Q.24
  clip_t clip [4];

  vst_mac u_mac (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (vtx_i.pos_x),
    .y_i    (vtx_i.pos_y),
    .z_i    (vtx_i.pos_z),
    .row_i  (row_q),
    .clip_o (clip)
  );

  // prep: magnitudes, quotient signs, overflow check (|a| >= |w| * 2^24 clamps)
  logic [ClipW-1:0] ua_q [3];
  logic [ClipW-1:0] uw_q;
  logic             neg_q [3];
  logic             ovf_q [3];
  logic             wz_q;

  always_ff @(posedge clk_i) begin
    logic [ClipW-1:0] uw;
    if (en) begin
      uw = clip[3][ClipW-1] ? ClipW'(-clip[3]) : clip[3];
      for (int i = 0; i < 3; i++) begin
        ua_q[i]  <= clip[i][ClipW-1] ? ClipW'(-clip[i]) : clip[i];
        neg_q[i] <= clip[i][ClipW-1] ^ clip[3][ClipW-1];
        ovf_q[i] <= ({{IntLimW{1'b0}}, (clip[i][ClipW-1] ? ClipW'(-clip[i]) : clip[i])})
                    >= {uw, {IntLimW{1'b0}}};
      end
      uw_q <= uw;
      wz_q <= (clip[3] == '0);
    end
  end

  // three divider lanes share the w magnitude
  logic [QuotW-1:0] quo  [3];
  logic             qneg [3];
  logic             qovf [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vst_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .ua_i  (ua_q[i]),
      .uw_i  (uw_q),
      .neg_i (neg_q[i]),
      .ovf_i (ovf_q[i]),
      .q_o   (quo[i]),
      .neg_o (qneg[i]),
      .ovf_o (qovf[i])
    );
  end

  // zero-w flag rides alongside the divider
  logic wz_dly_q [DivStages];

  always_ff @(posedge clk_i) begin
    if (en) begin
      wz_dly_q[0] <= wz_q;
      for (int s = 1; s < DivStages; s++) begin
        wz_dly_q[s] <= wz_dly_q[s-1];
      end
    end
  end

  logic [31:0] sx, sy, dz;
  logic        wz_out;

  vst_post u_post (
    .clk_i  (clk_i),
    .en_i   (en),
    .q_i    (quo),
    .neg_i  (qneg),
    .ovf_i  (qovf),
    .wz_i   (wz_dly_q[DivStages-1]),
    .vp_w_i (vp_w_q),
    .vp_h_i (vp_h_q),
    .fr_h_i (fr_h_q),
    .sx_o   (sx),
    .sy_o   (sy),
    .dz_o   (dz),
    .wz_o   (wz_out)
  );

  assign scr_o.valid    = vld_q[Latency-1];
  assign scr_o.screen_x = signed'(sx);
  assign scr_o.screen_y = signed'(sy);
  assign scr_o.depth    = signed'(dz);
  assign scr_o.w_zero   = wz_out;

endmodule
